### src/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg: shared definitions of the periodic timer bank
// Defaults, request and mode codes, payload records and the command and
// status records between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF  = 32;
  localparam int unsigned NUM_GROUPS     = 4;
  localparam int unsigned DELAY_MAX      = 65535;
  localparam int unsigned RESULT_CAP     = 16;
  localparam int unsigned CNT_W          = $clog2(RESULT_CAP + 1);

  // request codes
  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_SETUP   = 3'd1;
  localparam logic [2:0] REQ_STOP    = 3'd2;
  localparam logic [2:0] REQ_RESTART = 3'd3;
  localparam logic [2:0] REQ_DELAY   = 3'd4;
  localparam logic [2:0] REQ_GROUP   = 3'd5;

  // result kinds
  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    MODE_READY = 2'd0,
    MODE_DELAY = 2'd1,
    MODE_STOP  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  timer_index;
    logic [1:0]  group_index;
    logic [31:0] period_value;
    logic [31:0] timeout_value;
    logic [31:0] delay_amount;
  } req_t;

  typedef struct packed {
    logic       result_kind;
    logic [3:0] fired_timer;
    logic       late_event;
    logic       request_error;
    logic       last_result;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic tick_adv;
    logic scan_clr;
    logic rd_entry;
    logic use_req;
    logic scan_eval;
    logic hold_eval;
    logic hold_grp;
    logic setup_wr;
    logic mode_wr;
    logic ptr_inc;
    logic emit_pend;
    logic emit_status;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       idx_ok;
    logic       grp_ok;
    logic       amt_bad;
    logic       ptr_last;
    logic       ev_stall;
    logic       out_free;
    logic       pend_valid;
  } ctl_sts_t;

endpackage

### src/ptb_req_if.sv
// ----------------------------------------------------------------------------
// ptb_req_if: request channel of the periodic timer bank
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface ptb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [3:0]  timer_index;
  logic [1:0]  group_index;
  logic [31:0] period_value;
  logic [31:0] timeout_value;
  logic [31:0] delay_amount;

  modport source (
    output valid, req_type, timer_index, group_index, period_value,
           timeout_value, delay_amount,
    input  ready
  );

  modport sink (
    input  valid, req_type, timer_index, group_index, period_value,
           timeout_value, delay_amount,
    output ready
  );
endinterface

### src/ptb_rsp_if.sv
// ----------------------------------------------------------------------------
// ptb_rsp_if: result channel of the periodic timer bank
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface ptb_rsp_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [3:0] fired_timer;
  logic       late_event;
  logic       request_error;
  logic       last_result;

  modport source (
    output valid, result_kind, fired_timer, late_event, request_error,
           last_result,
    input  ready
  );

  modport sink (
    input  valid, result_kind, fired_timer, late_event, request_error,
           last_result,
    output ready
  );
endinterface

### src/ptb_ctrl.sv
// ----------------------------------------------------------------------------
// ptb_ctrl: sequencer of the periodic timer bank
// Accepts one item at a time and steps the datapath through the timer scan,
// single timer updates, group holds and the result pushes.
// ----------------------------------------------------------------------------
module ptb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptb_pkg::ctl_sts_t  sts,
  output ptb_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_FLUSH,
    ST_REQ_RD,
    ST_REQ_EV,
    ST_GRP_RD,
    ST_GRP_EV,
    ST_STATUS
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.req_type) inside
          ptb_pkg::REQ_TICK: begin
            cmd.tick_adv = 1'b1;
            cmd.scan_clr = 1'b1;
            state_nxt    = ST_SCAN_RD;
          end
          ptb_pkg::REQ_SETUP: begin
            cmd.setup_wr = sts.idx_ok;
            state_nxt    = ST_STATUS;
          end
          ptb_pkg::REQ_STOP, ptb_pkg::REQ_RESTART: begin
            cmd.mode_wr = sts.idx_ok;
            cmd.use_req = 1'b1;
            state_nxt   = ST_STATUS;
          end
          ptb_pkg::REQ_DELAY: begin
            if (sts.amt_bad || !sts.idx_ok) begin
              state_nxt = ST_STATUS;
            end else begin
              state_nxt = ST_REQ_RD;
            end
          end
          ptb_pkg::REQ_GROUP: begin
            if (sts.amt_bad || !sts.grp_ok) begin
              state_nxt = ST_STATUS;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = ST_GRP_RD;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_SCAN_RD: begin
        cmd.rd_entry = 1'b1;
        state_nxt    = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        if (!sts.ev_stall) begin
          cmd.scan_eval = 1'b1;
          if (sts.ptr_last) begin
            state_nxt = ST_FLUSH;
          end else begin
            cmd.ptr_inc = 1'b1;
            state_nxt   = ST_SCAN_RD;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_pend = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_REQ_RD: begin
        cmd.rd_entry = 1'b1;
        cmd.use_req  = 1'b1;
        state_nxt    = ST_REQ_EV;
      end
      ST_REQ_EV: begin
        cmd.hold_eval = 1'b1;
        cmd.use_req   = 1'b1;
        state_nxt     = ST_STATUS;
      end
      ST_GRP_RD: begin
        cmd.rd_entry = 1'b1;
        state_nxt    = ST_GRP_EV;
      end
      ST_GRP_EV: begin
        cmd.hold_eval = 1'b1;
        cmd.hold_grp  = 1'b1;
        if (sts.ptr_last) begin
          state_nxt = ST_STATUS;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = ST_GRP_RD;
        end
      end
      ST_STATUS: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

endmodule

### src/ptb_datapath.sv
// ----------------------------------------------------------------------------
// ptb_datapath: timer storage and evaluation of the periodic timer bank
// Holds the clock, the per-timer memories, the scan pointer, the pending
// firing and the output register; acts on controller commands.
// ----------------------------------------------------------------------------
module ptb_datapath #(
  parameter int unsigned NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF,
  parameter int unsigned TIME_BITS  = ptb_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ptb_pkg::ctl_cmd_t  cmd,
  input  ptb_pkg::req_t      req,
  input  logic               out_ready,
  output ptb_pkg::ctl_sts_t  sts,
  output logic               out_valid,
  output ptb_pkg::rsp_t      out_rsp
);

  localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned EXT_W = (IDX_W > 4) ? IDX_W : 4;
  localparam int unsigned CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  // latched request
  logic [2:0]  req_type_r;
  logic [3:0]  idx_r;
  logic [1:0]  grp_r;
  logic [31:0] per_r;
  logic [31:0] tmo_r;
  logic [31:0] amt_r;

  logic [TIME_BITS-1:0] now_r;

  // per-timer memories
  ptb_pkg::mode_t       mode_mem [NUM_TIMERS];
  logic [TIME_BITS-1:0] last_mem [NUM_TIMERS];
  logic [31:0]          per_mem  [NUM_TIMERS];
  logic [31:0]          tmo_mem  [NUM_TIMERS];
  logic [1:0]           grp_mem  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] written_r;
  logic [NUM_TIMERS-1:0] registered_r;

  // registered read of one entry
  ptb_pkg::mode_t       rd_mode_r;
  logic [TIME_BITS-1:0] rd_last_r;
  logic [31:0]          rd_per_r;
  logic [31:0]          rd_tmo_r;
  logic [1:0]           rd_grp_r;
  logic                 rd_written_r;
  logic                 rd_reg_r;

  logic [IDX_W-1:0]          ptr_r;
  logic [ptb_pkg::CNT_W-1:0] fire_cnt_r;
  logic                      pend_valid_r;
  logic [3:0]                pend_idx_r;
  logic                      pend_late_r;

  logic          out_valid_r;
  ptb_pkg::rsp_t out_rsp_r;

  logic [EXT_W-1:0]     idx_ext;
  logic [EXT_W-1:0]     ptr_ext;
  logic [IDX_W-1:0]     req_addr;
  logic [IDX_W-1:0]     addr;
  ptb_pkg::mode_t       eff_mode;
  logic [TIME_BITS-1:0] eff_last;
  logic [TIME_BITS-1:0] elapsed;
  logic [CMP_W-1:0]     el_c;
  logic                 due;
  logic                 late;
  logic                 hold_end;
  logic                 fire;
  logic                 wake;
  logic                 report;
  logic                 out_free;
  logic                 amt_bad;
  logic                 hold_ok;
  logic [TIME_BITS-1:0] hold_time;
  logic                 ml_we;
  ptb_pkg::mode_t       ml_mode;
  logic [TIME_BITS-1:0] ml_last;
  logic                 push;
  ptb_pkg::rsp_t        push_rsp;

  assign idx_ext  = EXT_W'(idx_r);
  assign ptr_ext  = EXT_W'(ptr_r);
  assign req_addr = idx_ext[IDX_W-1:0];
  assign addr     = cmd.use_req ? req_addr : ptr_r;

  // an entry never written reads as ready with last run zero
  assign eff_mode = rd_written_r ? rd_mode_r : ptb_pkg::MODE_READY;
  assign eff_last = rd_written_r ? rd_last_r : '0;

  assign elapsed  = now_r - eff_last;
  assign el_c     = CMP_W'(elapsed);
  assign due      = el_c >= CMP_W'(rd_per_r);
  assign late     = el_c > CMP_W'(rd_tmo_r);
  assign hold_end = el_c < CMP_W'(ptb_pkg::DELAY_MAX);
  assign fire     = rd_reg_r && (eff_mode == ptb_pkg::MODE_READY) && due;
  assign wake     = rd_reg_r && (eff_mode == ptb_pkg::MODE_DELAY) && hold_end;
  assign report   = fire && (fire_cnt_r < ptb_pkg::CNT_W'(ptb_pkg::RESULT_CAP));
  assign out_free = !out_valid_r || out_ready;
  assign amt_bad  = (amt_r == 32'd0) || (amt_r > 32'(ptb_pkg::DELAY_MAX));

  assign hold_ok   = (eff_mode != ptb_pkg::MODE_STOP) &&
                     (!cmd.hold_grp || (rd_reg_r && (rd_grp_r == grp_r)));
  assign hold_time = now_r + TIME_BITS'(amt_r);

  // mode and last-run write port
  always_comb begin
    ml_we   = 1'b0;
    ml_mode = ptb_pkg::MODE_READY;
    ml_last = now_r;
    if (cmd.scan_eval && (fire || wake)) begin
      ml_we = 1'b1;
    end else if (cmd.hold_eval && hold_ok) begin
      ml_we   = 1'b1;
      ml_mode = ptb_pkg::MODE_DELAY;
      ml_last = hold_time;
    end else if (cmd.mode_wr) begin
      ml_we = 1'b1;
      if (req_type_r == ptb_pkg::REQ_STOP) begin
        ml_mode = ptb_pkg::MODE_STOP;
        ml_last = '0;
      end
    end
  end

  // result push selection
  always_comb begin
    push     = 1'b0;
    push_rsp = '0;
    if (cmd.scan_eval && report && pend_valid_r) begin
      push                 = 1'b1;
      push_rsp.result_kind = ptb_pkg::KIND_FIRED;
      push_rsp.fired_timer = pend_idx_r;
      push_rsp.late_event  = pend_late_r;
    end else if (cmd.emit_pend) begin
      push                 = 1'b1;
      push_rsp.result_kind = ptb_pkg::KIND_FIRED;
      push_rsp.fired_timer = pend_idx_r;
      push_rsp.late_event  = pend_late_r;
      push_rsp.last_result = 1'b1;
    end else if (cmd.emit_status) begin
      push                   = 1'b1;
      push_rsp.result_kind   = ptb_pkg::KIND_STATUS;
      push_rsp.fired_timer   = (req_type_r == ptb_pkg::REQ_GROUP) ? 4'd0 : idx_r;
      push_rsp.request_error = amt_bad && ((req_type_r == ptb_pkg::REQ_DELAY) ||
                                           (req_type_r == ptb_pkg::REQ_GROUP));
      push_rsp.last_result   = 1'b1;
    end
  end

  always_comb begin
    sts            = '0;
    sts.req_type   = req_type_r;
    sts.idx_ok     = 32'(idx_r) < 32'(NUM_TIMERS);
    sts.grp_ok     = 32'(grp_r) < 32'(ptb_pkg::NUM_GROUPS);
    sts.amt_bad    = amt_bad;
    sts.ptr_last   = ptr_r == IDX_W'(NUM_TIMERS - 1);
    sts.ev_stall   = report && pend_valid_r && !out_free;
    sts.out_free   = out_free;
    sts.pend_valid = pend_valid_r;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r        <= '0;
      written_r    <= '0;
      registered_r <= '0;
      ptr_r        <= '0;
      fire_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.tick_adv) begin
        now_r <= now_r + TIME_BITS'(1);
      end
      if (ml_we) begin
        written_r[addr] <= 1'b1;
      end
      if (cmd.setup_wr) begin
        registered_r[req_addr] <= 1'b1;
      end
      if (cmd.scan_clr) begin
        ptr_r <= '0;
      end else if (cmd.ptr_inc) begin
        ptr_r <= ptr_r + IDX_W'(1);
      end
      if (cmd.scan_clr) begin
        fire_cnt_r <= '0;
      end else if (cmd.scan_eval && report) begin
        fire_cnt_r <= fire_cnt_r + ptb_pkg::CNT_W'(1);
      end
      if (cmd.scan_clr || cmd.emit_pend) begin
        pend_valid_r <= 1'b0;
      end else if (cmd.scan_eval && report) begin
        pend_valid_r <= 1'b1;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= req.req_type;
      idx_r      <= req.timer_index;
      grp_r      <= req.group_index;
      per_r      <= req.period_value;
      tmo_r      <= req.timeout_value;
      amt_r      <= req.delay_amount;
    end
    if (cmd.scan_eval && report) begin
      pend_idx_r  <= ptr_ext[3:0];
      pend_late_r <= late;
    end
    if (push) begin
      out_rsp_r <= push_rsp;
    end
  end

  // timer memories
  always_ff @(posedge clk) begin
    if (ml_we) begin
      mode_mem[addr] <= ml_mode;
      last_mem[addr] <= ml_last;
    end
    if (cmd.setup_wr) begin
      per_mem[req_addr] <= per_r;
      tmo_mem[req_addr] <= tmo_r;
      grp_mem[req_addr] <= grp_r;
    end
    if (cmd.rd_entry) begin
      rd_mode_r    <= mode_mem[addr];
      rd_last_r    <= last_mem[addr];
      rd_per_r     <= per_mem[addr];
      rd_tmo_r     <= tmo_mem[addr];
      rd_grp_r     <= grp_mem[addr];
      rd_written_r <= written_r[addr];
      rd_reg_r     <= registered_r[addr];
    end
  end

endmodule

### src/periodic_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_timer_bank: bank of periodic timers on one millisecond clock
// Ticks scan every timer for firings and hold ends; other requests register
// a timer or change the mode of one timer or of a whole group.
// ----------------------------------------------------------------------------
// one item at a time; in_req.ready returns high once an item is finished
// tick: a read and an evaluate step per timer through the shared entry memory;
//   setup, stop, restart and rejected holds: dispatch, then status; timer delay:
//   dispatch, entry read, evaluate, status; group delay: a read and an evaluate
//   step per timer; all plus stalls while a result waits
// reset (synchronous, active low) clears the clock, modes and registrations
module periodic_timer_bank #(
  parameter int unsigned NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF,
  parameter int unsigned TIME_BITS  = ptb_pkg::TIME_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  ptb_req_if.sink      in_req,
  ptb_rsp_if.source    out_rsp
);

  ptb_pkg::ctl_cmd_t cmd;
  ptb_pkg::ctl_sts_t sts;
  ptb_pkg::req_t     req;
  ptb_pkg::rsp_t     rsp;
  logic              in_ready;
  logic              out_valid;

  // gather the request fields into one record for the datapath
  always_comb begin
    req.req_type      = in_req.req_type;
    req.timer_index   = in_req.timer_index;
    req.group_index   = in_req.group_index;
    req.period_value  = in_req.period_value;
    req.timeout_value = in_req.timeout_value;
    req.delay_amount  = in_req.delay_amount;
  end

  assign in_req.ready = in_ready;

  // sequencer: dispatch, per-timer scan loop, result pushes
  ptb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // timer memories, clock, pending firing and output register
  ptb_datapath #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_BITS  (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .req       (req),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_rsp   (rsp)
  );

  // result item straight from the output register
  assign out_rsp.valid         = out_valid;
  assign out_rsp.result_kind   = rsp.result_kind;
  assign out_rsp.fired_timer   = rsp.fired_timer;
  assign out_rsp.late_event    = rsp.late_event;
  assign out_rsp.request_error = rsp.request_error;
  assign out_rsp.last_result   = rsp.last_result;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the periodic timer bank
// Sends tick, setup, stop, restart, timer delay and group delay items and
// checks every result against a predictor of the timer bank in the bench.
// ----------------------------------------------------------------------------
module tb;
  import ptb_pkg::*;

  localparam int          NT            = NUM_TIMERS_DEF;
  // settle wait covering a tick or a group delay, plus some slack
  localparam int          SETTLE_CYCLES = 2 * NT + 3 + 16;
  localparam int          CYCLE_LIMIT   = 400000;
  // request codes the block ignores
  localparam logic [2:0]  REQ_SPARE_6   = 3'd6;
  localparam logic [2:0]  REQ_SPARE_7   = 3'd7;

  logic clk;
  logic rst_n;

  ptb_req_if in_req();
  ptb_rsp_if out_rsp();

  periodic_timer_bank i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  // predictor copy of the timer bank state
  logic [31:0] bank_now;
  mode_t       bank_mode       [NT];
  logic [31:0] bank_last_run   [NT];
  logic [31:0] bank_period     [NT];
  logic [31:0] bank_timeout    [NT];
  logic [1:0]  bank_group      [NT];
  logic        bank_registered [NT];

  // results still owed by the block, oldest first
  rsp_t        pending_results[$];

  int          error_count;
  int          cycle_count;
  // chance in percent that a side idles in a given cycle
  int          send_idle_pct;
  int          recv_idle_pct;

  // 8 time unit clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog on the whole run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t watchdog expired with %0d results outstanding", $time,
                 pending_results.size());
        $display("[periodic_timer_bank] ERROR");
        $finish;
      end
    end
  end

  // result side back-pressure, redrawn every cycle
  initial begin
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic bit amount_out_of_range(logic [31:0] amt);
    return (amt == 32'd0) || (amt > DELAY_MAX);
  endfunction

  // a stopped timer ignores a hold; any other timer waits until now + amt
  function automatic void hold_timer_until(int t, logic [31:0] amt);
    if (bank_mode[t] != MODE_STOP) begin
      bank_mode[t]     = MODE_DELAY;
      bank_last_run[t] = bank_now + amt;
    end
  endfunction

  function automatic void clear_timer_bank();
    bank_now = '0;
    for (int i = 0; i < NT; i++) begin
      bank_mode[i]       = MODE_READY;
      bank_last_run[i]   = '0;
      bank_period[i]     = '0;
      bank_timeout[i]    = '0;
      bank_group[i]      = '0;
      bank_registered[i] = 1'b0;
    end
  endfunction

  // applies one accepted request and queues the results it should produce
  function automatic void predict_timer_events(req_t r);
    rsp_t        fired[$];
    rsp_t        s;
    logic [31:0] elapsed;
    logic        err;
    logic [3:0]  idx;

    err = 1'b0;
    idx = r.timer_index;
    case (r.req_type)
      REQ_TICK: begin
        bank_now = bank_now + 32'd1;
        for (int i = 0; i < NT; i++) begin
          if (bank_registered[i]) begin
            elapsed = bank_now - bank_last_run[i];
            if (bank_mode[i] == MODE_READY && elapsed >= bank_period[i]) begin
              bank_last_run[i] = bank_now;
              s.result_kind   = KIND_FIRED;
              s.fired_timer   = 4'(i);
              s.late_event    = (elapsed > bank_timeout[i]);
              s.request_error = 1'b0;
              s.last_result   = 1'b0;
              if (fired.size() < RESULT_CAP) fired.push_back(s);
            end else if (bank_mode[i] == MODE_DELAY && elapsed < DELAY_MAX) begin
              // hold is over, restart from now
              bank_last_run[i] = bank_now;
              bank_mode[i]     = MODE_READY;
            end
          end
        end
        // a quiet tick gives nothing back
        foreach (fired[k]) begin
          s = fired[k];
          s.last_result = (k == fired.size() - 1);
          pending_results.push_back(s);
        end
        return;
      end
      REQ_SETUP: begin
        bank_period[idx]     = r.period_value;
        bank_timeout[idx]    = r.timeout_value;
        bank_group[idx]      = r.group_index;
        bank_registered[idx] = 1'b1;
      end
      REQ_STOP: begin
        bank_mode[idx]     = MODE_STOP;
        bank_last_run[idx] = '0;
      end
      REQ_RESTART: begin
        bank_mode[idx]     = MODE_READY;
        bank_last_run[idx] = bank_now;
      end
      REQ_DELAY: begin
        if (amount_out_of_range(r.delay_amount)) err = 1'b1;
        else hold_timer_until(idx, r.delay_amount);
      end
      REQ_GROUP: begin
        // group status always names timer zero
        idx = '0;
        if (amount_out_of_range(r.delay_amount)) begin
          err = 1'b1;
        end else begin
          for (int i = 0; i < NT; i++)
            if (bank_registered[i] && bank_group[i] == r.group_index)
              hold_timer_until(i, r.delay_amount);
        end
      end
      default: return;  // spare codes are dropped silently
    endcase
    s.result_kind   = KIND_STATUS;
    s.fired_timer   = idx;
    s.late_event    = 1'b0;
    s.request_error = err;
    s.last_result   = 1'b1;
    pending_results.push_back(s);
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void compare_field(string name, logic [3:0] exp_v, logic [3:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t exp_r;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual kind %0d timer %0d",
                 $time, out_rsp.result_kind, out_rsp.fired_timer);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        compare_field("result_kind",   exp_r.result_kind,   out_rsp.result_kind);
        compare_field("fired_timer",   exp_r.fired_timer,   out_rsp.fired_timer);
        compare_field("late_event",    exp_r.late_event,    out_rsp.late_event);
        compare_field("request_error", exp_r.request_error, out_rsp.request_error);
        compare_field("last_result",   exp_r.last_result,   out_rsp.last_result);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic req_t make_req(logic [2:0] kind, logic [3:0] idx, logic [1:0] grp,
                                    logic [31:0] per, logic [31:0] tmo, logic [31:0] amt);
    req_t r;
    r.req_type      = kind;
    r.timer_index   = idx;
    r.group_index   = grp;
    r.period_value  = per;
    r.timeout_value = tmo;
    r.delay_amount  = amt;
    return r;
  endfunction

  // called just after a rising edge; returns at the edge that took the item
  task automatic send_req(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid         <= 1'b1;
    in_req.req_type      <= r.req_type;
    in_req.timer_index   <= r.timer_index;
    in_req.group_index   <= r.group_index;
    in_req.period_value  <= r.period_value;
    in_req.timeout_value <= r.timeout_value;
    in_req.delay_amount  <= r.delay_amount;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    predict_timer_events(r);
  endtask

  // sender holds off until every owed result is back and the block is quiet
  task automatic hold_until_drained();
    in_req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // periods and timeouts: mostly short so timers fire, sometimes any value
  function automatic logic [31:0] pick_span();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 32'($urandom_range(12));
    if (p < 88) return 32'($urandom_range(200));
    return $urandom();
  endfunction

  // hold amounts: mostly short holds, plus both range edges and wild values
  function automatic logic [31:0] pick_hold();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 32'($urandom_range(20, 1));
    if (p < 78) return 32'd0;
    if (p < 88) return 32'($urandom_range(DELAY_MAX + 5, DELAY_MAX - 5));
    return $urandom();
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, every request and the special cases
  task automatic test_directed_requests();
    // quiet tick with nothing registered
    send_req(make_req(REQ_TICK, 4'd0, 2'd0, '0, '0, '0));
    // zero period fires every tick, all-ones period never
    send_req(make_req(REQ_SETUP, 4'd0, 2'd0, 32'd0, 32'd0, '0));
    send_req(make_req(REQ_SETUP, 4'd15, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0));
    send_req(make_req(REQ_SETUP, 4'd5, 2'd2, 32'd2, 32'd1, '0));
    send_req(make_req(REQ_SETUP, 4'd6, 2'd2, 32'd3, 32'd5, '0));
    send_req(make_req(REQ_TICK, 4'd0, 2'd0, '0, '0, '0));
    send_req(make_req(REQ_TICK, 4'd0, 2'd0, '0, '0, '0));
    // hold amount zero, just above maximum and all ones are rejected
    send_req(make_req(REQ_DELAY, 4'd5, 2'd0, '0, '0, 32'd0));
    send_req(make_req(REQ_DELAY, 4'd5, 2'd0, '0, '0, DELAY_MAX + 1));
    send_req(make_req(REQ_DELAY, 4'd6, 2'd0, '0, '0, 32'hFFFF_FFFF));
    // maximum hold accepted, shortest hold ends on the next tick
    send_req(make_req(REQ_DELAY, 4'd5, 2'd0, '0, '0, DELAY_MAX));
    send_req(make_req(REQ_DELAY, 4'd0, 2'd0, '0, '0, 32'd1));
    send_req(make_req(REQ_TICK, 4'd0, 2'd0, '0, '0, '0));
    // group holds: populated group, empty group, bad amount
    send_req(make_req(REQ_GROUP, 4'd9, 2'd2, '0, '0, 32'd2));
    send_req(make_req(REQ_GROUP, 4'd3, 2'd1, '0, '0, 32'd3));
    send_req(make_req(REQ_GROUP, 4'd0, 2'd0, '0, '0, 32'd0));
    // stopped timer ignores a hold
    send_req(make_req(REQ_STOP, 4'd0, 2'd0, '0, '0, '0));
    send_req(make_req(REQ_DELAY, 4'd0, 2'd0, '0, '0, 32'd4));
    send_req(make_req(REQ_TICK, 4'd0, 2'd0, '0, '0, '0));
    send_req(make_req(REQ_RESTART, 4'd0, 2'd0, '0, '0, '0));
    // mode changes on a timer never registered
    send_req(make_req(REQ_STOP, 4'd9, 2'd0, '0, '0, '0));
    send_req(make_req(REQ_RESTART, 4'd9, 2'd0, '0, '0, '0));
    // spare codes give no result
    send_req(make_req(REQ_SPARE_6, 4'd1, 2'd1, '0, '0, '0));
    send_req(make_req(REQ_SPARE_7, 4'd2, 2'd2, '0, '0, '0));
    send_req(make_req(REQ_TICK, 4'd0, 2'd0, '0, '0, '0));
  endtask

  // tick-heavy random mix; spare codes do not count toward the total
  task automatic test_random_traffic(int count);
    int   sent;
    int   p;
    req_t r;
    sent = 0;
    while (sent < count) begin
      p = $urandom_range(99);
      r = make_req(REQ_TICK, 4'($urandom_range(15)), 2'($urandom_range(3)),
                   pick_span(), pick_span(), pick_hold());
      if (p < 46)      r.req_type = REQ_TICK;
      else if (p < 60) r.req_type = REQ_SETUP;
      else if (p < 66) r.req_type = REQ_STOP;
      else if (p < 75) r.req_type = REQ_RESTART;
      else if (p < 86) r.req_type = REQ_DELAY;
      else if (p < 94) r.req_type = REQ_GROUP;
      else             r.req_type = ($urandom_range(1) == 0) ? REQ_SPARE_6 : REQ_SPARE_7;
      send_req(r);
      if (r.req_type <= REQ_GROUP) sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    error_count   = 0;
    send_idle_pct = 26;
    recv_idle_pct = 62;
    clear_timer_bank();
    rst_n                <= 1'b0;
    in_req.valid         <= 1'b0;
    in_req.req_type      <= REQ_TICK;
    in_req.timer_index   <= '0;
    in_req.group_index   <= '0;
    in_req.period_value  <= '0;
    in_req.timeout_value <= '0;
    in_req.delay_amount  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // slow receiver first
    test_directed_requests();
    test_random_traffic(70);
    hold_until_drained();

    // then a slow sender
    send_idle_pct = 62;
    recv_idle_pct = 26;
    test_random_traffic(60);
    hold_until_drained();

    // back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(60);

    // drain and let the block go quiet; the watchdog bounds the wait
    hold_until_drained();
    if (error_count == 0) begin
      $display("[periodic_timer_bank] OK");
    end else begin
      $display("[periodic_timer_bank] ERROR");
    end
    $finish;
  end

endmodule
